// ===== rtl/core/buddy_block_allocator_macros.svh =====
// Assertion macros shared by the buddy allocator RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Check cons in the same cycle as ante
`define BBA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// Types and constants for the buddy block allocator.
// No dependencies; used by the engine and the top level.
`timescale 1ns / 1ps
package bba_pkg;

	localparam int ENT_W      = 6;
	localparam int E_START    = 5;
	localparam int E_USED     = 4;
	localparam int OFS_W      = 4;
	localparam int ORD_W      = 5;
	localparam int SIZE_W     = 12;
	localparam int ADDR_W     = 14;
	localparam int BORD_W     = 4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
	localparam logic FIT_BEST  = 1'b0;
	localparam logic FIT_FIRST = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	typedef logic [ENT_W-1:0] entry_t;

	typedef struct packed {
		logic              command;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] address;
		logic [BORD_W-1:0] block_order;
	} res_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module bba_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/bba_engine.sv =====
// Allocate/free sequencer over the granule table memory.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
module bba_engine #(
	parameter int PAGE_ORDER = 12,
	parameter int MIN_ORDER  = 4,
	parameter int POOL_PAGES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  bba_pkg::req_t req,
	output logic         ready,
	input  logic         fit_mode,
	output logic         res_valid,
	output bba_pkg::res_t res,
	input  logic         res_ready
);
	import bba_pkg::*;

	localparam int PG_BITS    = PAGE_ORDER - MIN_ORDER;
	localparam int GRAN_PAGE  = 1 << PG_BITS;
	localparam int GRANULES   = POOL_PAGES * GRAN_PAGE;
	localparam int POOL_BYTES = POOL_PAGES << PAGE_ORDER;
	localparam int AW         = $clog2(GRANULES);
	localparam int GW         = AW + 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT,
		S_F_RD, S_F_CHK, S_F_LOOP, S_F_BCHK, S_DONE
	} state_t;

	state_t            state_q;
	logic [GW-1:0]     g_q, bg_q, best_g_q, clr_q;
	logic [ORD_W-1:0]  t_q, o_q, best_o_q;
	logic              found_q;
	res_t              res_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	entry_t            ram_wdata, rd_e;

	bba_ram #(.WIDTH(ENT_W), .DEPTH(GRANULES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_e)
	);

	function automatic entry_t mk_entry(input logic used, input logic [ORD_W-1:0] o);
		logic [ORD_W-1:0] ofs;
		ofs = o - ORD_W'(MIN_ORDER);
		return {1'b1, used, ofs[OFS_W-1:0]};
	endfunction

	function automatic res_t mk_res(input status_t st, input logic [GW-1:0] g,
			input logic [ORD_W-1:0] o);
		logic [GW+MIN_ORDER-1:0] full;
		res_t r;
		full = {g, {MIN_ORDER{1'b0}}};
		r.status      = st;
		r.address     = ADDR_W'(full);
		r.block_order = BORD_W'(o);
		return r;
	endfunction

	// request decode
	logic [ORD_W-1:0]  blen_c, t_c;
	logic              too_large_c, bad_addr_c;
	always_comb begin
		blen_c = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (req.request_size[i]) begin
				blen_c = ORD_W'(i + 1);
			end
		end
		t_c = (blen_c > ORD_W'(MIN_ORDER)) ? blen_c : ORD_W'(MIN_ORDER);
		too_large_c = 32'(t_c) > PAGE_ORDER;
		bad_addr_c = (req.block_address[MIN_ORDER-1:0] != '0) ||
			(32'(req.block_address) >= POOL_BYTES);
	end

	// decode of the entry read back
	logic [ORD_W-1:0]  raw_o_c, o_c;
	logic              e_start_c, e_used_c;
	always_comb begin
		e_start_c = rd_e[E_START];
		e_used_c  = rd_e[E_USED];
		raw_o_c   = ORD_W'(rd_e[OFS_W-1:0]) + ORD_W'(MIN_ORDER);
		o_c       = (32'(raw_o_c) > PAGE_ORDER) ? ORD_W'(PAGE_ORDER) : raw_o_c;
	end

	// scan step
	logic [GW-1:0]     ng_c;
	logic              fit_c, take_c, scan_end_c;
	always_comb begin
		ng_c       = e_start_c ? g_q + (GW'(1) << (o_c - ORD_W'(MIN_ORDER))) : g_q + GW'(1);
		fit_c      = e_start_c && !e_used_c && (o_c >= t_q);
		take_c     = fit_c && (!found_q || (o_c < best_o_q));
		scan_end_c = ng_c >= GW'(GRANULES);
	end

	// merge step
	logic [GW-1:0]     bit_c;
	logic              merge_c, o_top_c, split_c;
	always_comb begin
		bit_c   = GW'(1) << (o_q - ORD_W'(MIN_ORDER));
		merge_c = e_start_c && !e_used_c && (raw_o_c == o_q);
		o_top_c = 32'(o_q) >= PAGE_ORDER;
		split_c = best_o_q > t_q;
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(g_q);
		ram_wdata = mk_entry(1'b0, o_q);
		ram_re    = 1'b0;
		ram_raddr = AW'(g_q);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(clr_q);
				ram_wdata = ((clr_q & GW'(GRAN_PAGE - 1)) == '0) ?
					mk_entry(1'b0, ORD_W'(PAGE_ORDER)) : '0;
			end
			S_A_RD, S_F_RD: begin
				ram_re = 1'b1;
			end
			S_A_SPLIT: begin
				ram_we = 1'b1;
				if (split_c) begin
					ram_waddr = AW'(best_g_q +
						(GW'(1) << (best_o_q - ORD_W'(1) - ORD_W'(MIN_ORDER))));
					ram_wdata = mk_entry(1'b0, best_o_q - ORD_W'(1));
				end else begin
					ram_waddr = AW'(best_g_q);
					ram_wdata = mk_entry(1'b1, t_q);
				end
			end
			S_F_LOOP: begin
				if (o_top_c) begin
					ram_we = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(g_q ^ bit_c);
				end
			end
			S_F_BCHK: begin
				ram_we = 1'b1;
				if (merge_c) begin
					ram_waddr = (bg_q < g_q) ? AW'(g_q) : AW'(bg_q);
					ram_wdata = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign ready     = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			g_q      <= '0;
			bg_q     <= '0;
			best_g_q <= '0;
			t_q      <= '0;
			o_q      <= '0;
			best_o_q <= '0;
			found_q  <= 1'b0;
			res_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == GW'(GRANULES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						if (req.command == CMD_ALLOC) begin
							if (too_large_c) begin
								res_q   <= mk_res(ST_TOO_LARGE, '0, '0);
								state_q <= S_DONE;
							end else begin
								t_q     <= t_c;
								g_q     <= '0;
								found_q <= 1'b0;
								state_q <= S_A_RD;
							end
						end else begin
							if (bad_addr_c) begin
								res_q   <= mk_res(ST_BAD_FREE, '0, '0);
								state_q <= S_DONE;
							end else begin
								g_q     <= GW'(req.block_address >> MIN_ORDER);
								state_q <= S_F_RD;
							end
						end
					end
				end
				S_A_RD: begin
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (take_c) begin
						best_g_q <= g_q;
						best_o_q <= o_c;
						found_q  <= 1'b1;
					end
					if (fit_c && (fit_mode == FIT_FIRST)) begin
						state_q <= S_A_SPLIT;
					end else if (scan_end_c) begin
						if (found_q || take_c) begin
							state_q <= S_A_SPLIT;
						end else begin
							res_q   <= mk_res(ST_NO_FREE, '0, '0);
							state_q <= S_DONE;
						end
					end else begin
						g_q     <= ng_c;
						state_q <= S_A_RD;
					end
				end
				S_A_SPLIT: begin
					if (split_c) begin
						best_o_q <= best_o_q - ORD_W'(1);
					end else begin
						res_q   <= mk_res(ST_OK, best_g_q, t_q);
						state_q <= S_DONE;
					end
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (!e_start_c || !e_used_c) begin
						res_q   <= mk_res(ST_BAD_FREE, '0, '0);
						state_q <= S_DONE;
					end else begin
						o_q     <= o_c;
						state_q <= S_F_LOOP;
					end
				end
				S_F_LOOP: begin
					if (o_top_c) begin
						res_q   <= mk_res(ST_OK, g_q, o_q);
						state_q <= S_DONE;
					end else begin
						bg_q    <= g_q ^ bit_c;
						state_q <= S_F_BCHK;
					end
				end
				S_F_BCHK: begin
					if (merge_c) begin
						if (bg_q < g_q) begin
							g_q <= bg_q;
						end
						o_q     <= o_q + ORD_W'(1);
						state_q <= S_F_LOOP;
					end else begin
						res_q   <= mk_res(ST_OK, g_q, o_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// Buddy block allocator: fit mode register, result register, engine instance.
// Depends on bba_pkg, bba_engine and buddy_block_allocator_macros.svh.
`timescale 1ns / 1ps
`include "buddy_block_allocator_macros.svh"
// One transaction at a time. After reset the granule table is initialized, one entry
// per cycle for all POOL_PAGES * 2^(PAGE_ORDER-MIN_ORDER) entries (1024 by default),
// with in_stall high. Allocate: idle takes the request (and ends the item when the
// request is too large), then each block record visited in the table scan is read
// and checked (reads of the one memory port), then one write per split and one to
// mark the block; a scan that finds no free block ends without writes. Free: idle
// ends the item on a bad address, else the entry is read and checked, then each buddy
// examined is read and checked (the check writes the final entry when the buddy does
// not merge), or the final write is made once the block reaches page size. Done returns
// to idle; the result register lets the next transaction start while a result waits.
module buddy_block_allocator #(
	parameter int PAGE_ORDER = 12,
	parameter int MIN_ORDER  = 4,
	parameter int POOL_PAGES = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [bba_pkg::SIZE_W-1:0]       request_size,
	input  logic [bba_pkg::ADDR_W-1:0]       block_address,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [bba_pkg::ADDR_W-1:0]       address,
	output logic [bba_pkg::BORD_W-1:0]       block_order
);
	import bba_pkg::*;

	logic  fit_mode_q;
	logic  eng_ready, res_valid, res_ready, out_valid_q;
	req_t  req;
	res_t  eng_res, out_q;

	assign req.command       = command;
	assign req.request_size  = request_size;
	assign req.block_address = block_address;

	assign in_stall  = !eng_ready;
	assign res_ready = !out_valid_q || !out_stall;

	bba_engine #(
		.PAGE_ORDER(PAGE_ORDER),
		.MIN_ORDER (MIN_ORDER),
		.POOL_PAGES(POOL_PAGES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(in_valid),
		.req      (req),
		.ready    (eng_ready),
		.fit_mode (fit_mode_q),
		.res_valid(res_valid),
		.res      (eng_res),
		.res_ready(res_ready)
	);

	// hold fit mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_BEST;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	// load result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= eng_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign address     = out_q.address;
	assign block_order = out_q.block_order;

	`BBA_ASSERT_SAME(a_err_zero, out_valid && (status != ST_OK), (address == '0) && (block_order == '0), "error result carries address or order")
	`BBA_ASSERT_SAME(a_ok_order, out_valid && (status == ST_OK), (32'(block_order) >= MIN_ORDER) && (32'(block_order) <= PAGE_ORDER), "ok result order out of range")
	`BBA_ASSERT_NEXT(a_one_txn, in_valid && !in_stall, in_stall, "engine took a second transaction while busy")

endmodule

// ===== verif/buddy_block_allocator_tb.sv =====
// Self-checking testbench for buddy_block_allocator: directed and random transactions.
// Depends on bba_pkg and the buddy_block_allocator RTL; holds its own allocator predictor.
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
	import bba_pkg::*;

	localparam int PG_ORD   = 12;
	localparam int MN_ORD   = 4;
	localparam int PAGES    = 4;
	localparam int GRAN     = PAGES << (PG_ORD - MN_ORD);
	localparam int POOL_B   = PAGES << PG_ORD;
	localparam int WD_LIMIT = 40000;
	localparam int SETTLE   = 8;

	typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} step_kind_t;
	typedef struct {
		step_kind_t kind;
		req_t       req;
		logic       mode;
	} plan_step_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] block_address;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic [ADDR_W-1:0] address;
	logic [BORD_W-1:0] block_order;

	// planning copy of the pool, used to pick live blocks to free
	logic [ENT_W-1:0] plan_tbl [GRAN];
	logic             plan_mode;
	int               live_blocks [$];
	// checking copy of the pool, advanced on accepted transactions
	logic [ENT_W-1:0] chk_tbl [GRAN];
	logic             chk_mode;

	plan_step_t pending [$];
	res_t       expected_res [$];
	bit         in_took;
	int         settle_cnt;
	int         accepted_cnt;
	int         quiet_cnt;
	int         errors;
	bit         gen_done;

	buddy_block_allocator #(
		.PAGE_ORDER(PG_ORD),
		.MIN_ORDER (MN_ORD),
		.POOL_PAGES(PAGES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.request_size (request_size),
		.block_address(block_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.address      (address),
		.block_order  (block_order)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [ENT_W-1:0] make_entry(input bit used, input int ord);
		return {1'b1, used, 4'(ord - MN_ORD)};
	endfunction

	function automatic void pool_reset(ref logic [ENT_W-1:0] tbl [GRAN]);
		for (int g = 0; g < GRAN; g++) tbl[g] = '0;
		for (int p = 0; p < PAGES; p++) tbl[p << (PG_ORD - MN_ORD)] = make_entry(1'b0, PG_ORD);
	endfunction

	// Apply one allocate or free to a pool table and return the block's answer
	function automatic res_t pool_step(ref logic [ENT_W-1:0] tbl [GRAN], input logic mode,
			input req_t r);
		res_t res;
		int t, g, o, bg, sel_g, sel_o;
		bit hit;
		logic [ENT_W-1:0] e;
		res.status = ST_OK;
		res.address = '0;
		res.block_order = '0;
		hit = 0;
		sel_g = 0;
		sel_o = 0;
		if (r.command == CMD_ALLOC) begin
			t = MN_ORD;
			while (t < 31 && (int'(r.request_size) >> t) != 0) t++;
			if (t > PG_ORD) begin
				res.status = ST_TOO_LARGE;
				return res;
			end
			g = 0;
			while (g < GRAN) begin
				e = tbl[g];
				if (!e[E_START]) begin
					g++;
					continue;
				end
				o = int'(e[3:0]) + MN_ORD;
				if (o > PG_ORD) o = PG_ORD;
				if (!e[E_USED] && o >= t) begin
					if (mode == FIT_FIRST) begin
						sel_g = g;
						sel_o = o;
						hit = 1;
						break;
					end
					if (!hit || o < sel_o) begin
						sel_g = g;
						sel_o = o;
						hit = 1;
					end
				end
				g += 1 << (o - MN_ORD);
			end
			if (!hit) begin
				res.status = ST_NO_FREE;
				return res;
			end
			// split down to the requested order, upper halves stay free
			while (sel_o > t) begin
				sel_o--;
				tbl[sel_g + (1 << (sel_o - MN_ORD))] = make_entry(1'b0, sel_o);
			end
			tbl[sel_g] = make_entry(1'b1, t);
			res.address = ADDR_W'(sel_g << MN_ORD);
			res.block_order = BORD_W'(t);
			return res;
		end
		if (r.block_address[MN_ORD-1:0] != '0 || int'(r.block_address) >= POOL_B) begin
			res.status = ST_BAD_FREE;
			return res;
		end
		g = int'(r.block_address) >> MN_ORD;
		e = tbl[g];
		if (!e[E_START] || !e[E_USED]) begin
			res.status = ST_BAD_FREE;
			return res;
		end
		o = int'(e[3:0]) + MN_ORD;
		if (o > PG_ORD) o = PG_ORD;
		// merge with the buddy while it is a free block of the same order
		while (o < PG_ORD) begin
			bg = g ^ (1 << (o - MN_ORD));
			e = tbl[bg];
			if (!e[E_START] || e[E_USED] || (int'(e[3:0]) + MN_ORD) != o) break;
			if (bg < g) begin
				tbl[g] = '0;
				g = bg;
			end else begin
				tbl[bg] = '0;
			end
			o++;
		end
		tbl[g] = make_entry(1'b0, o);
		res.address = ADDR_W'(g << MN_ORD);
		res.block_order = BORD_W'(o);
		return res;
	endfunction

	task automatic plan_item(input logic cmd, input int size, input int addr);
		plan_step_t s;
		res_t r;
		s.kind = K_ITEM;
		s.mode = 1'b0;
		s.req.command = cmd;
		s.req.request_size = SIZE_W'(size);
		s.req.block_address = ADDR_W'(addr);
		r = pool_step(plan_tbl, plan_mode, s.req);
		if (r.status == ST_OK) begin
			if (cmd == CMD_ALLOC) begin
				live_blocks.push_back(int'(r.address));
			end else begin
				for (int i = 0; i < live_blocks.size(); i++)
					if (live_blocks[i] == addr) begin
						live_blocks.delete(i);
						break;
					end
			end
		end
		pending.push_back(s);
	endtask

	task automatic plan_cfg(input logic mode);
		plan_step_t s;
		s.kind = K_CFG;
		s.req = '0;
		s.mode = mode;
		plan_mode = mode;
		pending.push_back(s);
	endtask

	task automatic plan_drain();
		plan_step_t s;
		s.kind = K_DRAIN;
		s.req = '0;
		s.mode = 1'b0;
		pending.push_back(s);
	endtask

	// Random transaction: mostly sane allocates and frees of live blocks, some noise
	task automatic plan_random();
		int pick, size, idx;
		pick = $urandom_range(99);
		if (pick < 45) begin
			idx = $urandom_range(99);
			if (idx < 60) size = $urandom_range(255);
			else if (idx < 85) size = $urandom_range(1023);
			else size = $urandom_range(4095);
			plan_item(CMD_ALLOC, size, $urandom_range(16383));
		end else if (pick < 87 && live_blocks.size() > 0) begin
			idx = $urandom_range(live_blocks.size() - 1);
			plan_item(CMD_FREE, $urandom_range(4095), live_blocks[idx]);
		end else if (pick < 93) begin
			plan_item(CMD_FREE, $urandom_range(4095), $urandom_range(1023) << MN_ORD);
		end else begin
			plan_item(logic'($urandom_range(1)), $urandom_range(4095), $urandom_range(16383));
		end
	endtask

	// Build the whole transaction list
	initial begin
		gen_done = 0;
		plan_mode = FIT_BEST;
		pool_reset(plan_tbl);
		plan_cfg(FIT_BEST);
		plan_item(CMD_ALLOC, 0, 16383);
		plan_item(CMD_ALLOC, 15, 0);
		plan_item(CMD_ALLOC, 16, 0);
		plan_item(CMD_ALLOC, 4095, 0);
		plan_item(CMD_ALLOC, 4095, 0);
		plan_item(CMD_ALLOC, 4095, 0);
		plan_item(CMD_ALLOC, 2048, 0);
		plan_item(CMD_FREE, 0, 0);
		plan_item(CMD_FREE, 4095, 0);
		plan_item(CMD_FREE, 0, 8);
		plan_item(CMD_FREE, 0, 16383);
		plan_item(CMD_FREE, 0, 48);
		plan_item(CMD_FREE, 0, 16);
		plan_item(CMD_FREE, 0, 32);
		plan_item(CMD_FREE, 0, 4096);
		plan_item(CMD_FREE, 0, 8192);
		plan_item(CMD_FREE, 0, 12288);
		plan_item(CMD_ALLOC, 1000, 0);
		plan_item(CMD_ALLOC, 100, 0);
		plan_item(CMD_ALLOC, 255, 0);
		for (int ph = 0; ph < 5; ph++) begin
			plan_cfg(logic'(~ph[0]));
			for (int i = 0; i < 250; i++) begin
				if (ph == 2 && i == 120) plan_drain();
				plan_random();
			end
		end
		gen_done = 1;
	end

	// Reset, then wait for everything to drain and report
	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (gen_done);
		while (pending.size() != 0 || expected_res.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Drive inputs at the falling edge
	always @(negedge clk or negedge arst_n) begin
		logic n_valid, n_we, n_wdata, n_cmd, n_ostall;
		logic [SIZE_W-1:0] n_size;
		logic [ADDR_W-1:0] n_addr;
		bit quiet;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we <= 1'b0;
			cfg_wdata <= 1'b0;
			command <= CMD_ALLOC;
			request_size <= '0;
			block_address <= '0;
			out_stall <= 1'b0;
			settle_cnt = 0;
		end else begin
			quiet = accepted_cnt >= 400 && accepted_cnt < 560;
			n_valid = in_valid;
			n_we = 1'b0;
			n_wdata = cfg_wdata;
			n_cmd = command;
			n_size = request_size;
			n_addr = block_address;
			n_ostall = !quiet && $urandom_range(99) < 21;
			// hold a stalled transaction, otherwise advance the list
			if (!in_valid || in_took) begin
				n_valid = 1'b0;
				if (pending.size() != 0) begin
					case (pending[0].kind)
						K_ITEM: begin
							if (quiet || $urandom_range(99) >= 21) begin
								n_valid = 1'b1;
								n_cmd = pending[0].req.command;
								n_size = pending[0].req.request_size;
								n_addr = pending[0].req.block_address;
								void'(pending.pop_front());
							end
						end
						K_DRAIN: begin
							if (expected_res.size() == 0) void'(pending.pop_front());
						end
						default: begin
							if (expected_res.size() != 0) begin
								settle_cnt = 0;
							end else if (settle_cnt < SETTLE) begin
								settle_cnt++;
							end else begin
								n_we = 1'b1;
								n_wdata = pending[0].mode;
								void'(pending.pop_front());
								settle_cnt = 0;
							end
						end
					endcase
				end
			end
			in_valid <= n_valid;
			cfg_we <= n_we;
			cfg_wdata <= n_wdata;
			command <= n_cmd;
			request_size <= n_size;
			block_address <= n_addr;
			out_stall <= n_ostall;
		end
	end

	// Predict on accepted requests, check accepted results, watch for hangs
	always @(posedge clk or negedge arst_n) begin
		req_t r;
		res_t want;
		if (!arst_n) begin
			in_took = 0;
			accepted_cnt = 0;
			quiet_cnt = 0;
			errors = 0;
			chk_mode = FIT_BEST;
			pool_reset(chk_tbl);
			expected_res.delete();
		end else begin
			in_took = in_valid && !in_stall;
			quiet_cnt++;
			if (cfg_we) chk_mode = cfg_wdata;
			if (in_took) begin
				r.command = command;
				r.request_size = request_size;
				r.block_address = block_address;
				expected_res.push_back(pool_step(chk_tbl, chk_mode, r));
				accepted_cnt++;
				quiet_cnt = 0;
			end
			if (out_valid && !out_stall) begin
				quiet_cnt = 0;
				if (expected_res.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result: status %0d address %0d order %0d",
						status, address, block_order);
				end else begin
					want = expected_res.pop_front();
					if (status !== want.status || address !== want.address ||
							block_order !== want.block_order) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: status %0d/%0d address %0d/%0d order %0d/%0d",
								want.status, status, want.address, address,
								want.block_order, block_order);
					end
				end
			end
			if (quiet_cnt >= WD_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
